[hdl/sfr_pkg.sv]
// Shared types, constants and helpers for the stream find/replace block.
package sfr_pkg;

    localparam int REG_BYTES = 16;
    localparam int NW        = 5;
    localparam int QDEPTH    = 4;
    localparam int QAW       = $clog2(QDEPTH);
    localparam int QCW       = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        CFG_FIND_LOW       = 3'd0,
        CFG_FIND_HIGH      = 3'd1,
        CFG_FIND_LENGTH    = 3'd2,
        CFG_REPLACE_LOW    = 3'd3,
        CFG_REPLACE_HIGH   = 3'd4,
        CFG_REPLACE_LENGTH = 3'd5
    } cfg_index_t;

    // One queued job: which source to emit from, how many bytes, and end/flag bits.
    typedef struct packed {
        logic          sel_repl;
        logic [NW-1:0] count;
        logic          last;
        logic          modified;
    } job_ctrl_t;

    function automatic logic [7:0] reg_byte(input logic [63:0] lo, input logic [63:0] hi,
                                            input logic [3:0] idx);
        logic [5:0] sh;
        sh = {idx[2:0], 3'b000};
        if (idx[3]) begin
            return hi[sh +: 8];
        end
        return lo[sh +: 8];
    endfunction

endpackage

[hdl/sfr_front.sv]
// Front end: accepts bytes, keeps the match window and turns each item that yields output or ends a stream into a job.
module sfr_front #(
    parameter int WIN_DEPTH = 16,
    parameter int CW        = 5,
    parameter int JOB_SLOTS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_in_byte,
    input  logic                          s_in_last,
    input  logic                          win_clear,
    input  logic [63:0]                   find_low,
    input  logic [63:0]                   find_high,
    input  logic [CW-1:0]                 find_len,
    input  logic [sfr_pkg::NW-1:0]        repl_len,
    input  logic                          q_full,
    output logic                          push,
    output sfr_pkg::job_ctrl_t            push_ctrl,
    output logic [JOB_SLOTS-1:0][7:0]     push_bytes
);

    logic [7:0]    win_reg  [WIN_DEPTH];
    logic [7:0]    win_next [WIN_DEPTH];
    logic [7:0]    w_new    [WIN_DEPTH];
    logic [CW-1:0] cnt_reg, cnt_next, cnt_eff;
    logic          mod_reg, mod_next;
    logic          accept, full, match;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cnt_eff = (cnt_reg >= find_len) ? '0 : cnt_reg;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            w_new[i] = (CW'(i) == cnt_eff) ? s_in_byte : win_reg[i];
        end
        full  = (find_len != '0) && (cnt_eff + CW'(1) == find_len);
        match = full;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            if (CW'(i) < find_len &&
                w_new[i] != sfr_pkg::reg_byte(find_low, find_high, 4'(i))) begin
                match = 1'b0;
            end
        end
    end

    always_comb begin
        win_next = w_new;
        cnt_next = cnt_eff;
        mod_next = mod_reg;
        push_ctrl.sel_repl = 1'b0;
        push_ctrl.count    = '0;
        push_ctrl.last     = s_in_last;
        push_bytes         = '0;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            push_bytes[i] = w_new[i];
        end

        if (find_len == '0) begin
            push_ctrl.count = sfr_pkg::NW'(1);
        end else if (match) begin
            push_ctrl.sel_repl = 1'b1;
            push_ctrl.count    = repl_len;
            mod_next           = 1'b1;
            cnt_next           = '0;
        end else if (full) begin
            // drop the oldest byte; on last the whole window is flushed
            push_ctrl.count = s_in_last ? sfr_pkg::NW'(find_len) : sfr_pkg::NW'(1);
            for (int i = 0; i < WIN_DEPTH - 1; i++) begin
                win_next[i] = w_new[i + 1];
            end
            cnt_next = find_len - CW'(1);
        end else begin
            push_ctrl.count = s_in_last ? sfr_pkg::NW'(cnt_eff + CW'(1)) : '0;
            cnt_next        = cnt_eff + CW'(1);
        end
        push_ctrl.modified = mod_next;

        if (find_len == '0 || s_in_last) begin
            cnt_next = '0;
        end
        if (s_in_last) begin
            mod_next = 1'b0;
        end
        push = accept && (push_ctrl.count != '0 || s_in_last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            mod_reg <= 1'b0;
        end else if (win_clear) begin
            cnt_reg <= '0;
        end else if (accept) begin
            cnt_reg <= cnt_next;
            mod_reg <= mod_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            win_reg <= win_next;
        end
    end

endmodule

[hdl/sfr_queue.sv]
// Short job queue between the front end and the emitter.
module sfr_queue #(
    parameter int JOB_SLOTS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  sfr_pkg::job_ctrl_t         push_ctrl,
    input  logic [JOB_SLOTS-1:0][7:0]  push_bytes,
    output logic                       full,
    input  logic                       pop,
    output logic                       head_valid,
    output sfr_pkg::job_ctrl_t         head_ctrl,
    output logic [JOB_SLOTS-1:0][7:0]  head_bytes
);

    sfr_pkg::job_ctrl_t              ctrl_q  [sfr_pkg::QDEPTH];
    logic [JOB_SLOTS-1:0][7:0]       bytes_q [sfr_pkg::QDEPTH];
    logic [sfr_pkg::QAW-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [sfr_pkg::QCW-1:0]         cnt_reg;
    logic                            do_push, do_pop;

    assign full       = (cnt_reg == sfr_pkg::QCW'(sfr_pkg::QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_ctrl  = ctrl_q[rd_ptr_reg];
    assign head_bytes = bytes_q[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + sfr_pkg::QAW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + sfr_pkg::QAW'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + sfr_pkg::QCW'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - sfr_pkg::QCW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            ctrl_q[wr_ptr_reg]  <= push_ctrl;
            bytes_q[wr_ptr_reg] <= push_bytes;
        end
    end

endmodule

[hdl/sfr_back.sv]
// Emitter: walks the head job one result per cycle into the output register while m_ready allows.
module sfr_back #(
    parameter int JOB_SLOTS = 16,
    parameter int IW        = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       head_valid,
    input  sfr_pkg::job_ctrl_t         head_ctrl,
    input  logic [JOB_SLOTS-1:0][7:0]  head_bytes,
    output logic                       pop,
    input  logic [63:0]                replace_low,
    input  logic [63:0]                replace_high,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [7:0]                 m_out_byte,
    output logic                       m_byte_valid,
    output logic                       m_run_last,
    output logic                       m_stream_end,
    output logic                       m_was_modified
);

    logic [sfr_pkg::NW-1:0] k_reg, k_next;
    logic                   m_valid_reg;
    logic [7:0]             byte_reg, byte_next;
    logic                   bv_reg, bv_next, rl_reg, rl_next, se_reg, se_next, mod_reg;
    logic                   load;

    assign load = head_valid && (!m_valid_reg || m_ready);

    always_comb begin
        bv_next = (head_ctrl.count != '0);
        rl_next = !bv_next || (k_reg + sfr_pkg::NW'(1) == head_ctrl.count);
        se_next = rl_next && head_ctrl.last;
        if (!bv_next) begin
            byte_next = 8'h00;
        end else if (head_ctrl.sel_repl) begin
            byte_next = sfr_pkg::reg_byte(replace_low, replace_high, k_reg[3:0]);
        end else begin
            byte_next = head_bytes[k_reg[IW-1:0]];
        end
        pop    = load && rl_next;
        k_next = k_reg;
        if (load) begin
            k_next = rl_next ? '0 : k_reg + sfr_pkg::NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            k_reg       <= '0;
        end else begin
            k_reg <= k_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= byte_next;
            bv_reg   <= bv_next;
            rl_reg   <= rl_next;
            se_reg   <= se_next;
            mod_reg  <= head_ctrl.modified;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = byte_reg;
    assign m_byte_valid   = bv_reg;
    assign m_run_last     = rl_reg;
    assign m_stream_end   = se_reg;
    assign m_was_modified = mod_reg;

endmodule

[hdl/stream_find_replace_top.sv]
// Top level of the stream find/replace block: register file and the three stages.
//
//   channel   direction  handshake              payload
//   cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//   s         in         s_valid / s_ready      s_in_byte, s_in_last
//   m         out        m_valid / m_ready      m_out_byte, m_byte_valid, m_run_last,
//                                               m_stream_end, m_was_modified
//
// An input byte is taken every cycle while the four-entry job queue has room; the
// emitter drives one result per cycle while m_ready allows; an item yields up to 16
// results or none, and a stream end with no bytes still yields one result.
// Reset empties the window and clears the sticky flag, the queue, the output valid and the config registers.
// The front end stalls only on a full queue; the output register stalls only on m_ready.
module stream_find_replace_top #(
    parameter int MAX_PATTERN = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_byte_valid,
    output logic        m_run_last,
    output logic        m_stream_end,
    output logic        m_was_modified
);

    localparam int WIN_DEPTH = (MAX_PATTERN < sfr_pkg::REG_BYTES) ? MAX_PATTERN
                                                                  : sfr_pkg::REG_BYTES;
    localparam int CW        = $clog2(WIN_DEPTH + 1);
    localparam int IW        = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
    localparam int JOB_SLOTS = 1 << IW;

    logic [63:0]            find_low_reg, find_high_reg, repl_low_reg, repl_high_reg;
    logic [4:0]             find_len_reg, repl_len_reg;
    logic [CW-1:0]          find_len_eff;
    logic [sfr_pkg::NW-1:0] repl_len_eff;
    logic                   cfg_we, win_clear;

    logic                       push, q_full, pop, head_valid;
    sfr_pkg::job_ctrl_t         push_ctrl, head_ctrl;
    logic [JOB_SLOTS-1:0][7:0]  push_bytes, head_bytes;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign win_clear = cfg_we && (sfr_pkg::cfg_index_t'(cfg_index) == sfr_pkg::CFG_FIND_LENGTH);

    // saturate the lengths to what the window and the registers hold
    assign find_len_eff = (find_len_reg > 5'(WIN_DEPTH)) ? CW'(WIN_DEPTH) : CW'(find_len_reg);
    assign repl_len_eff = (repl_len_reg > 5'(sfr_pkg::REG_BYTES))
                          ? sfr_pkg::NW'(sfr_pkg::REG_BYTES) : sfr_pkg::NW'(repl_len_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            find_low_reg  <= '0;
            find_high_reg <= '0;
            find_len_reg  <= '0;
            repl_low_reg  <= '0;
            repl_high_reg <= '0;
            repl_len_reg  <= '0;
        end else if (cfg_we) begin
            case (sfr_pkg::cfg_index_t'(cfg_index))
                sfr_pkg::CFG_FIND_LOW:       find_low_reg  <= cfg_data;
                sfr_pkg::CFG_FIND_HIGH:      find_high_reg <= cfg_data;
                sfr_pkg::CFG_FIND_LENGTH:    find_len_reg  <= cfg_data[4:0];
                sfr_pkg::CFG_REPLACE_LOW:    repl_low_reg  <= cfg_data;
                sfr_pkg::CFG_REPLACE_HIGH:   repl_high_reg <= cfg_data;
                sfr_pkg::CFG_REPLACE_LENGTH: repl_len_reg  <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    sfr_front #(
        .WIN_DEPTH (WIN_DEPTH),
        .CW        (CW),
        .JOB_SLOTS (JOB_SLOTS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .win_clear  (win_clear),
        .find_low   (find_low_reg),
        .find_high  (find_high_reg),
        .find_len   (find_len_eff),
        .repl_len   (repl_len_eff),
        .q_full     (q_full),
        .push       (push),
        .push_ctrl  (push_ctrl),
        .push_bytes (push_bytes)
    );

    sfr_queue #(
        .JOB_SLOTS (JOB_SLOTS)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ctrl  (push_ctrl),
        .push_bytes (push_bytes),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_ctrl  (head_ctrl),
        .head_bytes (head_bytes)
    );

    sfr_back #(
        .JOB_SLOTS (JOB_SLOTS),
        .IW        (IW)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (head_valid),
        .head_ctrl      (head_ctrl),
        .head_bytes     (head_bytes),
        .pop            (pop),
        .replace_low    (repl_low_reg),
        .replace_high   (repl_high_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_byte_valid   (m_byte_valid),
        .m_run_last     (m_run_last),
        .m_stream_end   (m_stream_end),
        .m_was_modified (m_was_modified)
    );

endmodule

[tb/sv/stream_find_replace_top_tb.sv]
// Self-checking testbench for the stream find/replace block with a built-in predictor.
`timescale 1ns / 100ps

module stream_find_replace_top_tb;

    localparam int MAX_PATTERN   = 16;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 32;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 38;
    localparam int PRESSURE_PHASE = 3;
    localparam longint TIMEOUT_NS = 64'd10_000_000;

    // Indexes the block does not decode; writes to them must change nothing.
    localparam logic [2:0] CFG_SPARE_6 = 3'd6;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       run_last;
        logic       stream_end;
        logic       modified;
    } result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data  = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = '0;
    logic        s_in_last = 1'b0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_byte_valid;
    logic        m_run_last;
    logic        m_stream_end;
    logic        m_was_modified;

    // Predictor copy of the configuration and of the matching window.
    logic [127:0] find_pat;
    logic [127:0] repl_pat;
    logic [4:0]   find_len;
    logic [4:0]   repl_len;
    logic [7:0]   held_bytes [0:sfr_pkg::REG_BYTES-1];
    int           held_count;
    logic         modified_seen;

    stream_item_t pending_bytes [$];
    result_t      expected_results [$];
    int           queued_count   = 0;
    int           accepted_count = 0;
    int           mismatch_count = 0;
    int           tx_gap = 0;
    int           rx_wait = 0;
    bit           tx_idle_on = 1'b0;
    bit           rx_idle_on = 1'b0;
    int           hold_req = 0;
    int           hold_ack = 0;

    stream_find_replace_top #(
        .MAX_PATTERN(MAX_PATTERN)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_in_last     (s_in_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_byte_valid  (m_byte_valid),
        .m_run_last    (m_run_last),
        .m_stream_end  (m_stream_end),
        .m_was_modified(m_was_modified)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("ERROR at %0t: %s got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Work out the results one accepted byte causes and queue them.
    task automatic predict_replace(input logic [7:0] b, input logic last);
        logic [7:0] emitted [0:2*sfr_pkg::REG_BYTES+1];
        int         n;
        int         flen;
        int         rlen;
        logic       hit;
        result_t    r;
        n = 0;
        flen = (find_len > sfr_pkg::REG_BYTES) ? sfr_pkg::REG_BYTES : int'(find_len);
        if (flen > MAX_PATTERN) flen = MAX_PATTERN;
        rlen = (repl_len > sfr_pkg::REG_BYTES) ? sfr_pkg::REG_BYTES : int'(repl_len);
        if (held_count >= flen) held_count = 0;
        if (flen == 0) begin
            emitted[n] = b;
            n++;
        end else begin
            held_bytes[held_count] = b;
            held_count++;
            if (held_count == flen) begin
                hit = 1'b1;
                for (int i = 0; i < flen; i++) begin
                    if (held_bytes[i] != find_pat[8*i +: 8]) hit = 1'b0;
                end
                if (hit) begin
                    modified_seen = 1'b1;
                    for (int i = 0; i < rlen; i++) begin
                        emitted[n] = repl_pat[8*i +: 8];
                        n++;
                    end
                    held_count = 0;
                end else begin
                    // Pass the oldest byte and slide the window.
                    emitted[n] = held_bytes[0];
                    n++;
                    for (int i = 0; i < flen - 1; i++) held_bytes[i] = held_bytes[i+1];
                    held_count--;
                end
            end
        end
        if (last) begin
            for (int i = 0; i < held_count; i++) begin
                emitted[n] = held_bytes[i];
                n++;
            end
            held_count = 0;
        end
        if (n == 0 && last) begin
            r = '{data: 8'h00, valid: 1'b0, run_last: 1'b1, stream_end: 1'b1,
                  modified: modified_seen};
            expected_results.push_back(r);
        end else begin
            for (int k = 0; k < n; k++) begin
                r.data       = emitted[k];
                r.valid      = 1'b1;
                r.run_last   = (k == n - 1);
                r.stream_end = (k == n - 1) && last;
                r.modified   = modified_seen;
                expected_results.push_back(r);
            end
        end
        if (last) modified_seen = 1'b0;
    endtask

    // Sender: one item in flight, random gap before each next item while sender gaps are on.
    always @(posedge aclk) begin
        logic         next_valid;
        stream_item_t item;
        next_valid = s_valid;
        if (!aresetn) begin
            next_valid = 1'b0;
            tx_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_replace(s_in_byte, s_in_last);
                accepted_count++;
                next_valid = 1'b0;
                tx_gap = tx_idle_on ? $urandom_range(0, 15) : 0;
            end
            if (!next_valid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_bytes.size() > 0) begin
                    item = pending_bytes.pop_front();
                    s_in_byte <= item.data;
                    s_in_last <= item.last;
                    next_valid = 1'b1;
                end
            end
        end
        s_valid <= next_valid;
    end

    // Receiver: compare each result with the oldest expectation, stall at random while receiver stalls are on.
    always @(posedge aclk) begin
        logic    next_ready;
        result_t want;
        if (!aresetn) begin
            next_ready = 1'b0;
            rx_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, out_byte", m_out_byte, 8'h00);
                end else begin
                    want = expected_results.pop_front();
                    if (m_out_byte !== want.data)
                        report_mismatch("out_byte", m_out_byte, want.data);
                    if (m_byte_valid !== want.valid)
                        report_mismatch("byte_valid", 8'(m_byte_valid), 8'(want.valid));
                    if (m_run_last !== want.run_last)
                        report_mismatch("run_last", 8'(m_run_last), 8'(want.run_last));
                    if (m_stream_end !== want.stream_end)
                        report_mismatch("stream_end", 8'(m_stream_end),
                                        8'(want.stream_end));
                    if (m_was_modified !== want.modified)
                        report_mismatch("was_modified", 8'(m_was_modified),
                                        8'(want.modified));
                end
                rx_wait = rx_idle_on ? $urandom_range(0, 15) : 0;
            end
            if (hold_req != hold_ack) begin
                hold_ack = hold_req;
                rx_wait = LONG_HOLD;
            end
            if (rx_wait > 0) begin
                rx_wait--;
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
        end
        m_ready <= next_ready;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            sfr_pkg::CFG_FIND_LOW:       find_pat[63:0]   = val;
            sfr_pkg::CFG_FIND_HIGH:      find_pat[127:64] = val;
            sfr_pkg::CFG_FIND_LENGTH: begin
                find_len   = val[4:0];
                held_count = 0;
            end
            sfr_pkg::CFG_REPLACE_LOW:    repl_pat[63:0]   = val;
            sfr_pkg::CFG_REPLACE_HIGH:   repl_pat[127:64] = val;
            sfr_pkg::CFG_REPLACE_LENGTH: repl_len = val[4:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Lengths carry random upper bits that the block must ignore.
    task automatic configure(input logic [127:0] fpat, input logic [4:0] flen,
                             input logic [127:0] rpat, input logic [4:0] rlen);
        write_reg(sfr_pkg::CFG_FIND_LOW, fpat[63:0]);
        write_reg(sfr_pkg::CFG_FIND_HIGH, fpat[127:64]);
        write_reg(sfr_pkg::CFG_FIND_LENGTH,
                  {$urandom, 27'($urandom_range(0, 32'h07FF_FFFF)), flen});
        write_reg(sfr_pkg::CFG_REPLACE_LOW, rpat[63:0]);
        write_reg(sfr_pkg::CFG_REPLACE_HIGH, rpat[127:64]);
        write_reg(sfr_pkg::CFG_REPLACE_LENGTH,
                  {$urandom, 27'($urandom_range(0, 32'h07FF_FFFF)), rlen});
    endtask

    task automatic queue_item(input logic [7:0] b, input logic last);
        pending_bytes.push_back('{data: b, last: last});
        queued_count++;
    endtask

    // Mostly whole patterns with random stream ends, plus prefixes and noise.
    task automatic queue_random_items(input int count, input bit close_stream);
        int         left;
        int         seg;
        int         plen;
        int         eff;
        logic [7:0] seg_bytes [0:sfr_pkg::REG_BYTES-1];
        logic       last;
        left = count;
        eff = (find_len > sfr_pkg::REG_BYTES) ? sfr_pkg::REG_BYTES : int'(find_len);
        while (left > 0) begin
            seg = $urandom_range(0, 9);
            if (seg < 5 && eff > 0) begin
                plen = eff;
            end else if (seg < 7 && eff > 1) begin
                plen = $urandom_range(1, eff - 1);
            end else begin
                plen = 0;
            end
            if (plen > 0) begin
                for (int i = 0; i < plen; i++) seg_bytes[i] = find_pat[8*i +: 8];
            end else begin
                plen = $urandom_range(1, 3);
                for (int i = 0; i < plen; i++) seg_bytes[i] = 8'($urandom_range(0, 255));
            end
            for (int i = 0; i < plen && left > 0; i++) begin
                last = (left == 1) ? close_stream : ($urandom_range(0, 11) == 0);
                queue_item(seg_bytes[i], last);
                left--;
            end
        end
    endtask

    // Wait for every queued item to be taken and every result to come out.
    task automatic wait_drained();
        int guard;
        guard = 0;
        while ((accepted_count != queued_count || expected_results.size() > 0)
               && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [127:0] fp;
        logic [127:0] rp;
        logic [4:0]   fl;
        logic [4:0]   rl;
        int           half;
        find_pat = '0;
        repl_pat = '0;
        find_len = '0;
        repl_len = '0;
        held_count = 0;
        modified_seen = 1'b0;
        for (int i = 0; i < sfr_pkg::REG_BYTES; i++) held_bytes[i] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero find length: bytes pass straight through; spare indexes ignored.
        configure('0, 5'd0, '0, 5'd0);
        write_reg(CFG_SPARE_6, '1);
        write_reg(CFG_SPARE_7, {$urandom, $urandom});
        queue_item(8'h00, 1'b0);
        queue_item(8'hFF, 1'b1);
        wait_drained();

        // Empty replacement: silent match mid-stream, end marker on a final match.
        configure({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FF5A_FF00}, 5'd3, '1, 5'd0);
        queue_item(8'h00, 1'b0);
        queue_item(8'hFF, 1'b0);
        queue_item(8'h5A, 1'b0);
        queue_item(8'h00, 1'b0);
        queue_item(8'hFF, 1'b0);
        queue_item(8'h5A, 1'b1);
        // Leave two bytes pending; the next length write drops them.
        queue_item(8'h00, 1'b0);
        queue_item(8'hFF, 1'b0);
        wait_drained();

        // Oversized lengths saturate to full sixteen-byte pattern and replacement.
        fp = {$urandom, $urandom, $urandom, $urandom};
        rp = {$urandom, $urandom, $urandom, $urandom};
        configure(fp, 5'd31, rp, 5'd31);
        for (int i = 0; i < sfr_pkg::REG_BYTES; i++)
            queue_item(fp[8*i +: 8], i == sfr_pkg::REG_BYTES - 1);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            tx_idle_on = (phase != 0) && (phase != 5) && (phase != PRESSURE_PHASE);
            rx_idle_on = (phase != 0) && (phase != 6);
            fp = {$urandom, $urandom, $urandom, $urandom};
            rp = {$urandom, $urandom, $urandom, $urandom};
            case ($urandom_range(0, 5))
                0: fl = 5'd0;
                1: fl = 5'd1;
                2: fl = 5'($urandom_range(2, 4));
                3: fl = 5'($urandom_range(5, 15));
                4: fl = 5'd16;
                default: fl = 5'($urandom_range(17, 31));
            endcase
            case ($urandom_range(0, 3))
                0: rl = 5'd0;
                1: rl = 5'($urandom_range(1, 3));
                2: rl = 5'($urandom_range(4, 16));
                default: rl = 5'($urandom_range(17, 31));
            endcase
            if (phase == PRESSURE_PHASE) begin
                fl = 5'd2;
                rl = 5'd16;
            end
            configure(fp, fl, rp, rl);
            // Hold the receiver off while the sender keeps offering items.
            if (phase == PRESSURE_PHASE) hold_req++;
            half = PHASE_ITEMS / 2;
            queue_random_items(half, 1'b0);
            wait_drained();
            queue_random_items(PHASE_ITEMS - half, 1'($urandom_range(0, 1)));
            wait_drained();
        end

        if (expected_results.size() != 0)
            report_mismatch("results never arrived, count", 8'(expected_results.size()),
                            8'h00);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule
